// ===== src/floppy_controller_register_interface_core_macros.svh =====
// Assertion macros for the floppy controller register interface.
`ifndef FLOPPY_CONTROLLER_REGISTER_INTERFACE_CORE_MACROS_SVH
`define FLOPPY_CONTROLLER_REGISTER_INTERFACE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define FCRI_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FCRI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`else
`define FCRI_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define FCRI_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== src/fcri_pkg.sv =====
// Types and constants shared by the floppy controller register interface.
package fcri_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] port;
        logic [7:0] write_data;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       forwarded;
    } t_out_beat;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [1:0] idx;
        logic [7:0] data;
    } t_buf_req;

    typedef struct packed {
        logic       cmd_wr;
        logic       res_rd;
        logic [7:0] data;
    } t_fdc_req;

    localparam logic MODE_WRITE = 1'b1;

    localparam logic [7:0] PORT_MODE_A     = 8'hB1;
    localparam logic [7:0] PORT_MODE_B     = 8'hB5;
    localparam logic [7:0] PORT_ID_A       = 8'hB2;
    localparam logic [7:0] PORT_ID_B       = 8'hB6;
    localparam logic [7:0] PORT_BUF_FIRST  = 8'hD0;
    localparam logic [7:0] PORT_BUF_STACK  = 8'hD3;
    localparam logic [7:0] PORT_BUF_ZERO   = 8'hD4;
    localparam logic [7:0] PORT_BUF_LAST   = 8'hD7;
    localparam logic [7:0] PORT_STATUS     = 8'hDC;
    localparam logic [7:0] PORT_DATA       = 8'hDD;

    localparam logic [7:0] ID_VALUE        = 8'h03;
    localparam logic [7:0] NO_DATA         = 8'hFF;
    localparam int         EXT_BIT         = 2;

    localparam int         DRIVE_COUNT     = 2;
    localparam int         CMD_KEEP        = 6;
    localparam logic [3:0] CMD_MAX         = 4'd9;
    localparam int         RES_DEPTH       = 7;

    localparam logic [3:0] OP_WRITE_DATA   = 4'h5;
    localparam logic [3:0] OP_READ_DATA    = 4'h6;
    localparam logic [3:0] OP_RECALIBRATE  = 4'h7;
    localparam logic [3:0] OP_SENSE_INT    = 4'h8;
    localparam logic [3:0] OP_SEEK         = 4'hF;

    localparam logic [3:0] CMD_LEN_TABLE [16] = '{
        4'd0, 4'd0, 4'd0, 4'd3, 4'd2, 4'd9, 4'd9, 4'd2,
        4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd0, 4'd3
    };

    localparam logic [7:0] ST0_DRIVE_ABSENT = 8'h08;
    localparam logic [7:0] ST0_SEEK_DONE    = 8'h20;
    localparam logic [7:0] ST0_ABNORMAL     = 8'h40;
    localparam logic [7:0] ST0_INVALID      = 8'h80;
    localparam logic [7:0] MS_DATA_READY    = 8'h80;
    localparam logic [7:0] MS_TO_HOST       = 8'h40;

endpackage

// ===== src/fcri_buffers.sv =====
// LIFO buffer stacks sharing one byte memory with a registered read port.
module fcri_buffers #(
    parameter int BUFFER_DEPTH = 256,
    parameter int BUFFER_COUNT = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  fcri_pkg::t_buf_req i_req,
    output logic              o_avail,
    output logic [7:0]        o_q
);
    import fcri_pkg::*;

    localparam int MEM_DEPTH = BUFFER_COUNT * BUFFER_DEPTH;
    localparam int FILL_W    = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [7:0]        r_mem [MEM_DEPTH];
    logic [7:0]        r_q;
    logic [FILL_W-1:0] r_fill [BUFFER_COUNT];

    logic [BUFFER_COUNT-1:0] w_hit;
    logic [FILL_W-1:0]       w_fill;
    logic                    w_any_hit;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_push_ok;
    logic                    w_pop_ok;
    logic [ADDR_W-1:0]       w_base;
    logic [ADDR_W-1:0]       w_waddr;
    logic [ADDR_W-1:0]       w_raddr;

    always_comb begin
        w_fill = '0;
        for (int b = 0; b < BUFFER_COUNT; b++) begin
            w_hit[b] = (i_req.idx == 2'(b));
            if (w_hit[b]) begin
                w_fill = w_fill | r_fill[b];
            end
        end
    end

    assign w_any_hit = |w_hit;
    assign w_full    = (w_fill == FILL_W'(BUFFER_DEPTH));
    assign w_empty   = (w_fill == '0);
    assign w_push_ok = i_go && i_req.push && w_any_hit && !w_full;
    assign w_pop_ok  = i_go && i_req.pop && w_any_hit && !w_empty;
    assign o_avail   = w_any_hit && !w_empty;

    assign w_base  = ADDR_W'(int'(i_req.idx) * BUFFER_DEPTH);
    assign w_waddr = w_base + ADDR_W'(w_fill);
    assign w_raddr = w_base + ADDR_W'(w_fill - FILL_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[w_waddr] <= i_req.data;
        end
        if (w_pop_ok) begin
            r_q <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BUFFER_COUNT; b++) begin
                r_fill[b] <= '0;
            end
        end else begin
            for (int b = 0; b < BUFFER_COUNT; b++) begin
                if (w_hit[b] && w_push_ok) begin
                    r_fill[b] <= r_fill[b] + FILL_W'(1);
                end else if (w_hit[b] && w_pop_ok) begin
                    r_fill[b] <= r_fill[b] - FILL_W'(1);
                end
            end
        end
    end

    assign o_q = r_q;

endmodule

// ===== src/fcri_fdc.sv =====
// Command collection, command execution, result stack and status registers.
module fcri_fdc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  fcri_pkg::t_fdc_req i_req,
    input  logic [1:0]         i_drives_present,
    output logic [7:0]         o_res_data,
    output logic [7:0]         o_main_status
);
    import fcri_pkg::*;

    logic [7:0] r_cmd [CMD_KEEP];
    logic [3:0] r_cmd_cnt;
    logic [7:0] r_res [RES_DEPTH];
    logic [2:0] r_res_cnt;
    logic [7:0] r_seek_status;
    logic [7:0] r_seek_cyl;
    logic       r_seek_done;
    logic [7:0] r_main;

    logic [7:0] w_cmd [CMD_KEEP];
    logic [3:0] w_slot;
    logic [3:0] w_next_cnt;
    logic [3:0] w_op;
    logic [3:0] w_len;
    logic       w_run;
    logic [1:0] w_drv;
    logic       w_ready;
    logic [7:0] w_cyl;

    function automatic logic drive_ready(input logic [1:0] drv, input logic [1:0] present);
        logic ok;
        ok = 1'b0;
        if (drv == 2'd0) begin
            ok = present[0] && (DRIVE_COUNT > 0);
        end else if (drv == 2'd1) begin
            ok = present[1] && (DRIVE_COUNT > 1);
        end
        return ok;
    endfunction

    always_comb begin
        w_slot = (r_cmd_cnt >= CMD_MAX) ? 4'd0 : r_cmd_cnt;
        for (int k = 0; k < CMD_KEEP; k++) begin
            w_cmd[k] = (w_slot == 4'(k)) ? i_req.data : r_cmd[k];
        end
    end

    assign w_next_cnt = w_slot + 4'd1;
    assign w_op       = w_cmd[0][3:0];
    assign w_len      = CMD_LEN_TABLE[w_op];
    assign w_run      = (w_len != 4'd0) && (w_len == w_next_cnt);
    assign w_drv      = w_cmd[1][1:0];
    assign w_ready    = drive_ready(w_drv, i_drives_present);
    assign w_cyl      = (w_op == OP_RECALIBRATE) ? 8'h00 : w_cmd[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CMD_KEEP; k++) begin
                r_cmd[k] <= '0;
            end
            for (int k = 0; k < RES_DEPTH; k++) begin
                r_res[k] <= '0;
            end
            r_cmd_cnt     <= '0;
            r_res_cnt     <= '0;
            r_seek_status <= '0;
            r_seek_cyl    <= '0;
            r_seek_done   <= 1'b0;
            r_main        <= MS_DATA_READY;
        end else if (i_go) begin
            if (i_req.cmd_wr) begin
                for (int k = 0; k < CMD_KEEP; k++) begin
                    if (w_slot == 4'(k)) begin
                        r_cmd[k] <= i_req.data;
                    end
                end
                if (w_len == 4'd0) begin
                    r_cmd_cnt <= '0;
                end else if (w_run) begin
                    r_cmd_cnt <= '0;
                    case (w_op)
                        OP_WRITE_DATA, OP_READ_DATA: begin
                            r_res[0]  <= w_cmd[5];
                            r_res[1]  <= w_cmd[4];
                            r_res[2]  <= w_cmd[3];
                            r_res[3]  <= w_cmd[2];
                            r_res[4]  <= 8'h00;
                            r_res[5]  <= 8'h00;
                            r_res[6]  <= w_ready ? 8'h00 : ST0_DRIVE_ABSENT;
                            r_res_cnt <= 3'd7;
                            r_main    <= MS_DATA_READY | MS_TO_HOST;
                        end
                        OP_SENSE_INT: begin
                            if (r_seek_done) begin
                                r_seek_done <= 1'b0;
                                r_res[0]    <= r_seek_cyl;
                                r_res[1]    <= r_seek_status;
                            end else begin
                                r_res[0] <= 8'h00;
                                r_res[1] <= ST0_INVALID;
                            end
                            r_res_cnt <= 3'd2;
                            r_main    <= MS_DATA_READY | MS_TO_HOST;
                        end
                        OP_RECALIBRATE, OP_SEEK: begin
                            r_res_cnt <= '0;
                            if (w_op == OP_RECALIBRATE) begin
                                r_cmd[2] <= 8'h00;
                            end
                            if (!w_ready) begin
                                r_seek_status <= ST0_ABNORMAL | ST0_SEEK_DONE | ST0_DRIVE_ABSENT
                                               | {6'b0, w_drv};
                                r_seek_done   <= 1'b0;
                                r_seek_cyl    <= 8'h00;
                            end else begin
                                r_seek_status <= ST0_SEEK_DONE | {6'b0, w_drv};
                                r_seek_done   <= 1'b1;
                                r_seek_cyl    <= w_cyl;
                            end
                        end
                        default: begin
                            r_res_cnt <= '0;
                        end
                    endcase
                end else begin
                    r_cmd_cnt <= w_next_cnt;
                end
            end
            if (i_req.res_rd && (r_res_cnt != 3'd0)) begin
                if (r_res_cnt == 3'd1) begin
                    r_main <= MS_DATA_READY;
                end
                r_res_cnt <= r_res_cnt - 3'd1;
            end
        end
    end

    assign o_res_data    = (r_res_cnt != 3'd0) ? r_res[3'(r_res_cnt - 3'd1)] : NO_DATA;
    assign o_main_status = r_main;

endmodule

// ===== src/floppy_controller_register_interface_core.sv =====
// Top level of the floppy controller register interface: port decode and beat pipeline.
//
// Input channel: one beat per port access (mode, port, write_data), taken on
// i_in_valid & o_in_ready. Output channel: one beat per access (read_data,
// forwarded), offered on o_out_valid and taken on i_out_ready.
// Configuration: APB write of drives_present at byte address 0.
// Path: an accepted beat is held in the input register, is decoded and
// applied to the controller state and the buffer memory as it moves into
// the second stage, and then lands in the output register; a stall can
// hold it in any stage.
// Throughput: one access per cycle while i_out_ready stays high; the buffer
// memory's read port and the state update are both registered.
// Reset: all control state, fill counts and status return to their initial
// values; buffer contents stay as they are and no sweep runs.
// Stall: when the receiver holds i_out_ready low the three stages fill up,
// then o_in_ready drops; no beat is lost or repeated.
`include "floppy_controller_register_interface_core_macros.svh"

module floppy_controller_register_interface_core #(
    parameter int BUFFER_DEPTH = 256,
    parameter int BUFFER_COUNT = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fcri_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fcri_pkg::t_out_beat o_out_beat,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fcri_pkg::*;

    logic       r_drives_present;
    logic [1:0] r_drives;
    logic       r_ext;
    logic       n_ext;

    logic       r_s1_valid;
    t_in_beat   r_s1;
    logic       r_s2_valid;
    logic [7:0] r_s2_rd;
    logic       r_s2_fwd;
    logic       r_s2_mem;
    logic [7:0] n_s2_rd;
    logic       n_s2_fwd;
    logic       n_s2_mem;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic       w_out_free;
    logic       w_s2_go;
    logic       w_s2_free;
    logic       w_s1_go;
    logic       w_s1_free;
    logic       w_buf_port;
    logic       w_cfg_wr;

    t_buf_req   w_buf_req;
    t_fdc_req   w_fdc_req;
    logic       w_buf_avail;
    logic [7:0] w_buf_q;
    logic [7:0] w_res_data;
    logic [7:0] w_main_status;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_s2_go    = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s1_go    = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign o_in_ready = w_s1_free;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == 1'b0) ? {30'b0, r_drives} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drives         <= '0;
            r_drives_present <= 1'b0;
        end else if (w_cfg_wr && (paddr[2] == 1'b0)) begin
            r_drives         <= pwdata[1:0];
            r_drives_present <= |pwdata[1:0];
        end
    end

    // Decode the access held in the input register
    assign w_buf_port = r_s1.port inside {[PORT_BUF_FIRST:PORT_BUF_LAST]};

    always_comb begin
        w_buf_req      = '0;
        w_fdc_req      = '0;
        w_buf_req.idx  = r_s1.port[1:0];
        w_buf_req.data = r_s1.write_data;
        w_fdc_req.data = r_s1.write_data;
        n_ext          = r_ext;
        n_s2_rd        = 8'h00;
        n_s2_fwd       = 1'b0;
        if (r_s1.mode == MODE_WRITE) begin
            if (r_s1.port inside {PORT_MODE_A, PORT_MODE_B}) begin
                n_ext = r_s1.write_data[EXT_BIT];
            end else if (w_buf_port) begin
                if (r_ext) begin
                    n_s2_fwd = 1'b1;
                end else begin
                    w_buf_req.push = (r_s1.port <= PORT_BUF_STACK);
                end
            end else if (r_s1.port == PORT_DATA) begin
                w_fdc_req.cmd_wr = 1'b1;
            end
        end else begin
            n_s2_rd = NO_DATA;
            if (r_s1.port inside {PORT_ID_A, PORT_ID_B}) begin
                n_s2_rd = ID_VALUE;
            end else if (w_buf_port) begin
                if (r_ext) begin
                    n_s2_fwd = 1'b1;
                    n_s2_rd  = 8'h00;
                end else if (r_s1.port <= PORT_BUF_STACK) begin
                    w_buf_req.pop = 1'b1;
                end else if (r_s1.port == PORT_BUF_ZERO) begin
                    n_s2_rd = 8'h00;
                end
            end else if (r_s1.port == PORT_STATUS) begin
                n_s2_rd = w_main_status;
            end else if (r_s1.port == PORT_DATA) begin
                w_fdc_req.res_rd = 1'b1;
                n_s2_rd          = w_res_data;
            end
        end
    end

    assign n_s2_mem = w_buf_req.pop && w_buf_avail;

    fcri_buffers #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_buffers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_s1_go),
        .i_req   (w_buf_req),
        .o_avail (w_buf_avail),
        .o_q     (w_buf_q)
    );

    fcri_fdc u_fdc (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (w_s1_go),
        .i_req            (w_fdc_req),
        .i_drives_present (r_drives),
        .o_res_data       (w_res_data),
        .o_main_status    (w_main_status)
    );

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ext       <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= w_s1_go;
            end
            if (w_out_free) begin
                r_out_valid <= w_s2_go;
            end
            if (w_s1_go) begin
                r_ext <= n_ext;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_in_valid) begin
            r_s1 <= i_in_beat;
        end
        if (w_s1_go) begin
            r_s2_rd  <= n_s2_rd;
            r_s2_fwd <= n_s2_fwd;
            r_s2_mem <= n_s2_mem;
        end
        if (w_s2_go) begin
            r_out.read_data <= r_s2_mem ? w_buf_q : r_s2_rd;
            r_out.forwarded <= r_s2_fwd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `FCRI_ASSERT(a_fwd_reads_zero, o_out_valid && o_out_beat.forwarded |-> o_out_beat.read_data == 8'h00, "forwarded beat carries nonzero data")
    `FCRI_ASSERT(a_accept_fills_s1, i_in_valid && o_in_ready |=> r_s1_valid, "accepted beat missing from input register")
    `FCRI_ASSERT_CLK(a_main_status_legal, i_clk, i_rst_n, w_main_status == MS_DATA_READY || w_main_status == (MS_DATA_READY | MS_TO_HOST), "main status out of range")
    `FCRI_ASSERT(a_drives_flag, r_drives_present == (r_drives != 2'b00), "drive summary out of step")

endmodule
